@@ rtl/core/kbsc_pkg.sv @@
// ----------------------------------------------------------------------------
// kbsc_pkg
// Shared widths and constants of the keyed byte stream cipher.
// ----------------------------------------------------------------------------
package kbsc_pkg;

  localparam int BYTE_W            = 8;
  localparam int STATE_W           = 64;
  localparam int HALF_W            = 32;
  localparam int LEN_REG_W         = 5;
  localparam int LEN_W             = 6;
  localparam int CFG_INDEX_W       = 2;
  localparam int CFG_DATA_W        = 64;
  localparam int KEY_BYTES_DEFAULT = 16;
  localparam int KEY_REG_BYTES     = 8;

  localparam logic [STATE_W-1:0] GOLDEN_GAMMA = 64'h9E3779B97F4A7C15;
  localparam logic [STATE_W-1:0] MIX_MULT_A   = 64'hBF58476D1CE4E5B9;
  localparam logic [STATE_W-1:0] MIX_MULT_B   = 64'h95D049BB133111EB;
  localparam logic [BYTE_W-1:0]  BYTE_BIAS    = 8'h88;

  localparam int FOLD_SHL  = 13;
  localparam int FOLD_SHR  = 17;
  localparam int FOLD_DROP = 5;
  localparam int MIX_SHR_A = 30;
  localparam int MIX_SHR_B = 27;
  localparam int MIX_SHR_C = 31;

  typedef enum logic [1:0] {
    CFG_KEY_LOW  = 2'd0,
    CFG_KEY_HIGH = 2'd1,
    CFG_KEY_LEN  = 2'd2,
    CFG_MODE     = 2'd3
  } cfg_index_t;

endpackage

@@ rtl/core/kbsc_if.sv @@
// ----------------------------------------------------------------------------
// kbsc_in_if / kbsc_out_if
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface kbsc_in_if;
  logic                        valid;
  logic                        ready;
  logic [kbsc_pkg::BYTE_W-1:0] data_byte;
  logic                        message_start;

  modport source (output valid, output data_byte, output message_start, input ready);
  modport sink   (input valid, input data_byte, input message_start, output ready);
endinterface

interface kbsc_out_if;
  logic                        valid;
  logic                        ready;
  logic [kbsc_pkg::BYTE_W-1:0] result_byte;

  modport source (output valid, output result_byte, input ready);
  modport sink   (input valid, input result_byte, output ready);
endinterface

@@ rtl/core/keyed_byte_stream_cipher_top.sv @@
// ----------------------------------------------------------------------------
// keyed_byte_stream_cipher_top
// Keyed byte stream cipher: one data word in, one transformed word out.
// ----------------------------------------------------------------------------
// Usage:
//   feed   carries a data byte and a message_start flag; a word is taken at a
//          clock edge with valid and ready high. Set message_start on the
//          first byte of a message to reseed the state from the key.
//   result carries the transformed byte under valid/ready.
//   cfg_we/cfg_index/cfg_data write the key words, key length and mode;
//   write them only while no word is in flight.
// Timing: one shared 32x32 multiplier forms each 64-bit splitmix product in
//   three passes, two products per word, so a word goes through accept,
//   six multiply passes, one shift-or mix step and one cipher step. The result
//   appears and feed.ready rises at the same edge, so a new word is taken only
//   after the previous word has finished.
// Stall: a finished result sits in the output register; if it is still held
//   when the next word finishes, the cipher step waits until it is taken.
// Reset (rst, synchronous): clear state and key position, key words to zero,
//   key length to one, mode to encrypt, drop any pending result.
// ----------------------------------------------------------------------------
module keyed_byte_stream_cipher_top #(
  parameter int KEY_BYTES = kbsc_pkg::KEY_BYTES_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  kbsc_in_if.sink                          feed,
  kbsc_out_if.source                       result,
  input  logic                             cfg_we,
  input  logic [kbsc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [kbsc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int POS_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int SW    = kbsc_pkg::STATE_W;
  localparam int HW    = kbsc_pkg::HALF_W;
  localparam int BW    = kbsc_pkg::BYTE_W;
  localparam int LW    = kbsc_pkg::LEN_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_MIX,
    ST_CIPHER
  } state_t;

  function automatic logic [7:0] rotl8(input logic [7:0] v, input logic [2:0] n);
    logic [15:0] w;
    w = {v, v} << n;
    return w[15:8];
  endfunction

  function automatic logic [7:0] rotr8(input logic [7:0] v, input logic [2:0] n);
    logic [15:0] w;
    w = {v, v} >> n;
    return w[7:0];
  endfunction

  // configuration registers
  logic [SW-1:0]                      key_bytes_low;
  logic [SW-1:0]                      key_bytes_high;
  logic [kbsc_pkg::LEN_REG_W-1:0]     key_length;
  logic                               decrypt_mode;

  // running state
  state_t        state;
  logic [SW-1:0] mix_state;
  logic [POS_W-1:0] key_position;
  logic [1:0]    phase;
  logic          round;
  logic [SW-1:0] opa;
  logic [SW-1:0] acc;
  logic [BW-1:0] data_hold;
  logic [BW-1:0] key_hold;
  logic          out_valid;
  logic [BW-1:0] out_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_bytes_low  <= '0;
      key_bytes_high <= '0;
      key_length     <= kbsc_pkg::LEN_REG_W'(1);
      decrypt_mode   <= 1'b0;
    end else if (cfg_we) begin
      case (kbsc_pkg::cfg_index_t'(cfg_index))
        kbsc_pkg::CFG_KEY_LOW:  key_bytes_low  <= cfg_data;
        kbsc_pkg::CFG_KEY_HIGH: key_bytes_high <= cfg_data;
        kbsc_pkg::CFG_KEY_LEN:  key_length     <= cfg_data[kbsc_pkg::LEN_REG_W-1:0];
        kbsc_pkg::CFG_MODE:     decrypt_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // key bytes as an array; bytes past the two key words read as zero
  logic [BW-1:0] key_arr [KEY_BYTES];
  for (genvar i = 0; i < KEY_BYTES; i++) begin : g_key
    if (i < kbsc_pkg::KEY_REG_BYTES) begin : g_low
      assign key_arr[i] = key_bytes_low[i*BW +: BW];
    end else if (i < 2 * kbsc_pkg::KEY_REG_BYTES) begin : g_high
      assign key_arr[i] = key_bytes_high[(i-kbsc_pkg::KEY_REG_BYTES)*BW +: BW];
    end else begin : g_zero
      assign key_arr[i] = '0;
    end
  end

  // effective key length, clamped to 1..KEY_BYTES
  logic [LW-1:0] len_raw;
  logic [LW-1:0] eff_len;
  assign len_raw = LW'(key_length);
  always_comb begin
    if (len_raw == '0) begin
      eff_len = LW'(1);
    end else if (len_raw > LW'(KEY_BYTES)) begin
      eff_len = LW'(KEY_BYTES);
    end else begin
      eff_len = len_raw;
    end
  end

  // key fold for reseed
  logic [BW:0]   fold_x;
  logic [SW-1:0] fold_a;
  logic [SW-1:0] fold_b;
  logic [SW-1:0] seed;
  always_comb begin
    fold_x = '0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (LW'(i) < eff_len) begin
        fold_x = fold_x ^ ({1'b0, key_arr[i]} + (BW+1)'(1));
      end
    end
    fold_a = SW'(fold_x);
    fold_a = fold_a ^ (fold_a << kbsc_pkg::FOLD_SHL);
    fold_b = fold_a ^ (fold_a >> kbsc_pkg::FOLD_SHR);
    seed   = fold_b >> kbsc_pkg::FOLD_DROP;
  end

  // key position for the word at the port
  logic [POS_W-1:0] pos_cur;
  logic [POS_W-1:0] pos_next;
  logic [LW-1:0]    pos_wide;
  logic [SW-1:0]    base_state;
  logic [SW-1:0]    z_add;
  always_comb begin
    if (feed.message_start || (LW'(key_position) >= eff_len)) begin
      pos_cur = '0;
    end else begin
      pos_cur = key_position;
    end
    pos_wide = LW'(pos_cur) + LW'(1);
    if (pos_wide >= eff_len) begin
      pos_next = '0;
    end else begin
      pos_next = pos_wide[POS_W-1:0];
    end
    base_state = feed.message_start ? seed : mix_state;
    z_add      = base_state + kbsc_pkg::GOLDEN_GAMMA;
  end

  // shared 32x32 multiplier, partial products of a 64-bit low product
  logic [SW-1:0] mul_const;
  logic [HW-1:0] mul_a;
  logic [HW-1:0] mul_b;
  logic [SW-1:0] prod;
  logic [HW-1:0] acc_hi_sum;
  logic [SW-1:0] prod_done;
  always_comb begin
    mul_const = round ? kbsc_pkg::MIX_MULT_B : kbsc_pkg::MIX_MULT_A;
    case (phase)
      2'd0: begin
        mul_a = opa[HW-1:0];
        mul_b = mul_const[HW-1:0];
      end
      2'd1: begin
        mul_a = opa[SW-1:HW];
        mul_b = mul_const[HW-1:0];
      end
      default: begin
        mul_a = opa[HW-1:0];
        mul_b = mul_const[SW-1:HW];
      end
    endcase
    prod       = {{HW{1'b0}}, mul_a} * {{HW{1'b0}}, mul_b};
    acc_hi_sum = acc[SW-1:HW] + prod[HW-1:0];
    prod_done  = {acc_hi_sum, acc[HW-1:0]};
  end

  // shift-or mix of the finished product
  logic [SW-1:0] z_fin;
  logic [4:0]    mix_r;
  logic [4:0]    mix_l;
  logic [SW-1:0] mixed;
  always_comb begin
    z_fin = acc ^ (acc >> kbsc_pkg::MIX_SHR_C);
    mix_r = z_fin[4:0];
    mix_l = 5'(6'd32 - {1'b0, mix_r});
    mixed = (z_fin >> mix_r) | (z_fin << mix_l);
  end

  // byte transform
  logic [BW-1:0] enc_byte;
  logic [BW-1:0] dec_byte;
  logic [BW-1:0] cipher_byte;
  always_comb begin
    enc_byte = data_hold + kbsc_pkg::BYTE_BIAS + key_hold;
    enc_byte = rotl8(enc_byte, mix_state[2:0]);
    enc_byte = enc_byte ^ mix_state[BW-1:0];
    enc_byte = rotl8(enc_byte, key_hold[2:0]);
    dec_byte = rotr8(data_hold, key_hold[2:0]);
    dec_byte = dec_byte ^ mix_state[BW-1:0];
    dec_byte = rotr8(dec_byte, mix_state[2:0]);
    dec_byte = dec_byte - kbsc_pkg::BYTE_BIAS - key_hold;
    cipher_byte = decrypt_mode ? dec_byte : enc_byte;
  end

  // load the output register when the cipher step can hand over its word
  logic out_load;
  assign out_load = (state == ST_CIPHER) && (!out_valid || result.ready);

  assign feed.ready         = (state == ST_IDLE);
  assign result.valid       = out_valid;
  assign result.result_byte = out_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      mix_state    <= '0;
      key_position <= '0;
      phase        <= '0;
      round        <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      // drop the result once taken, unless a new one replaces it
      if (result.ready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (feed.valid) begin
            data_hold    <= feed.data_byte;
            key_hold     <= key_arr[pos_cur];
            key_position <= pos_next;
            opa          <= z_add ^ (z_add >> kbsc_pkg::MIX_SHR_A);
            phase        <= '0;
            round        <= 1'b0;
            state        <= ST_MUL;
          end
        end
        ST_MUL: begin
          case (phase)
            2'd0: begin
              acc   <= prod;
              phase <= 2'd1;
            end
            2'd1: begin
              acc   <= prod_done;
              phase <= 2'd2;
            end
            default: begin
              acc   <= prod_done;
              phase <= 2'd0;
              if (round) begin
                state <= ST_MIX;
              end else begin
                // second splitmix round works on the first product
                opa   <= prod_done ^ (prod_done >> kbsc_pkg::MIX_SHR_B);
                round <= 1'b1;
              end
            end
          endcase
        end
        ST_MIX: begin
          mix_state <= mixed;
          state     <= ST_CIPHER;
        end
        ST_CIPHER: begin
          // hold until the output register is free
          if (out_load) begin
            out_byte  <= cipher_byte;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
